/* hw/rtl/mbmc_pkg.sv */
// ----------------------------------------------------------------------------
// mbmc_pkg
// Types, constants and table functions shared by the move-body munge and
// checksum block.
// ----------------------------------------------------------------------------
package mbmc_pkg;

   localparam int LANES = 4;

   localparam logic [7:0]  PROTECTED_BYTES = 8'd60;
   localparam logic [7:0]  COUNT_SAT       = 8'hFF;
   localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
   localparam logic [7:0]  MIX_BASE        = 8'hA5;
   localparam logic [7:0]  MOD255          = 8'hFF;
   localparam logic [2:0]  FULL_COUNT      = 3'd4;

   typedef enum logic [0:0] {
      CSR_SEQUENCE_KEY = 1'b0,
      CSR_UNMUNGE_MODE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0] in_word;
      logic [2:0]  in_byte_count;
      logic        in_last;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic [2:0]  out_byte_count;
      logic        out_last;
      logic [7:0]  checksum_byte;
   } rsp_payload_type;

   // crc stage control: an item moves from the munge stage into the crc stage
   typedef struct packed {
      logic       take;
      logic       last;
      logic [2:0] count;
   } crc_ctl_type;

   typedef struct packed {
      logic [31:0] result;
      logic [31:0] plain;
      logic [2:0]  count;
      logic        last;
      logic [31:0] key;
   } s1_type;

   typedef struct packed {
      logic [31:0] result;
      logic [2:0]  count;
      logic        last;
      logic [31:0] crc;
      logic [9:0]  seed;
   } s2_type;

   typedef struct packed {
      logic [31:0] result;
      logic [2:0]  count;
      logic        last;
      logic [31:0] crc;
      logic [31:0] tail;
   } s3_type;

   function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
      logic [31:0] v;
      v = {24'd0, idx};
      for (int b = 0; b < 8; b++) begin
         v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
      end
      return v;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      return crc_table_entry(crc[7:0] ^ b) ^ {8'd0, crc[31:8]};
   endfunction

   function automatic logic [7:0] mix_table(input logic [3:0] idx);
      logic [7:0] r;
      unique case (idx)
         4'd0:    r = 8'h7A;
         4'd1:    r = 8'h64;
         4'd2:    r = 8'h05;
         4'd3:    r = 8'hF1;
         4'd4:    r = 8'h1B;
         4'd5:    r = 8'h9B;
         4'd6:    r = 8'hA0;
         4'd7:    r = 8'hB5;
         4'd8:    r = 8'hCA;
         4'd9:    r = 8'hED;
         4'd10:   r = 8'h61;
         4'd11:   r = 8'h0D;
         4'd12:   r = 8'h4A;
         4'd13:   r = 8'hDF;
         4'd14:   r = 8'h8E;
         default: r = 8'hC7;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] lane_bits(input logic [1:0] lane);
      logic [7:0] r;
      unique case (lane)
         2'd0:    r = 8'h00;
         2'd1:    r = 8'h03;
         2'd2:    r = 8'h0A;
         default: r = 8'h1B;
      endcase
      return r;
   endfunction

   // key mod 1020 = 4 * ((key >> 2) mod 255) + key[1:0]; mod 255 by byte folding
   function automatic logic [9:0] seed_of(input logic [31:0] key);
      logic [9:0] sum;
      logic [8:0] fold;
      logic [8:0] red;
      sum  = {2'd0, key[9:2]} + {2'd0, key[17:10]} + {2'd0, key[25:18]}
           + {4'd0, key[31:26]};
      fold = {1'b0, sum[7:0]} + {7'd0, sum[9:8]};
      red  = (fold >= {1'b0, MOD255}) ? (fold - {1'b0, MOD255}) : fold;
      return {red[7:0], key[1:0]};
   endfunction

   // four crc table bytes, little-endian, starting at the given byte offset
   function automatic logic [31:0] tail_bytes(input logic [9:0] seed);
      logic [31:0] r;
      logic [9:0]  off;
      logic [31:0] ent;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         off = seed + 10'(i);
         ent = crc_table_entry(off[9:2]);
         r[8*i +: 8] = ent[{off[1:0], 3'b000} +: 8];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/mbmc_lane.sv */
// ----------------------------------------------------------------------------
// mbmc_lane
// One byte lane of the word munge: key XOR, byte swap, table mix and
// inverted-key XOR folded into a single byte path.
// ----------------------------------------------------------------------------
module mbmc_lane
   import mbmc_pkg::*;
(
   input  logic [1:0] lane_idx,
   input  logic       unmunge,
   input  logic [3:0] group,
   input  logic [7:0] src_byte,   // input byte from the swapped lane
   input  logic [7:0] src_key,    // key byte of the swapped lane
   input  logic [7:0] dst_key,    // key byte of this lane
   output logic [7:0] out_byte
);

   logic [1:0] mix_sel;
   logic [7:0] mix;

   // unmunge mixes before the swap, so it uses the mix of the source lane
   assign mix_sel  = unmunge ? ~lane_idx : lane_idx;
   assign mix      = MIX_BASE | lane_bits(mix_sel) | mix_table(group + {2'd0, mix_sel});
   assign out_byte = src_byte ^ src_key ^ mix ^ ~dst_key;

endmodule

/* hw/rtl/mbmc_crc.sv */
// ----------------------------------------------------------------------------
// mbmc_crc
// Merging stage: running reflected CRC-32 over the first protected plain
// bytes of the body, with the saturating plain byte counter.
// ----------------------------------------------------------------------------
module mbmc_crc
   import mbmc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   input  logic [31:0] plain_word,
   output logic [31:0] crc_next
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [7:0]  count_ff;
   logic [7:0]  count_in;
   logic [8:0]  count_sum;

   always_comb begin
      logic [31:0] c;
      logic [8:0]  pos;
      c = crc_ff;
      for (int i = 0; i < LANES; i++) begin
         pos = {1'b0, count_ff} + 9'(i);
         if ((3'(i) < ctl.count) && (pos < {1'b0, PROTECTED_BYTES})) begin
            c = crc_byte(c, plain_word[8*i +: 8]);
         end
      end
      crc_next = c;
   end

   assign count_sum = {1'b0, count_ff} + {6'd0, ctl.count};

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      if (ctl.take) begin
         if (ctl.last) begin
            crc_in   = CRC_INIT;
            count_in = '0;
         end else begin
            crc_in   = crc_next;
            count_in = count_sum[8] ? COUNT_SAT : count_sum[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         count_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/move_body_munge_and_checksum.sv */
// ----------------------------------------------------------------------------
// move_body_munge_and_checksum
// Packet body munge/unmunge with a reflected CRC-32 checksum byte.
// ----------------------------------------------------------------------------
// Body words enter on req_ and leave on rsp_, one result per item, in order.
// Throughput is one item per clock while the receiver does not stall. Four
// byte lanes munge the word on entry, the crc stage folds up to
// four plain bytes into the running CRC, the next stage looks up the four
// key-selected table bytes, and the output register absorbs them and forms the
// checksum byte. The running CRC and the word group counter are the loops
// across items. Write sequence_key and unmunge_mode through csr_ while no item is
// in flight; both are sampled when an item is accepted.
// ----------------------------------------------------------------------------
module move_body_munge_and_checksum
   import mbmc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  csr_index_type   csr_index,
   input  logic [31:0]     csr_data
);

   logic [31:0] key_ff;
   logic        mode_ff;
   logic [5:0]  group_ff;
   logic [5:0]  group_in;

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic load1, load2, load3, load_o;
   logic accept;

   s1_type          s1_ff, s1_in;
   s2_type          s2_ff, s2_in;
   s3_type          s3_ff, s3_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [2:0]  count_clamp;
   logic        full;
   logic [31:0] munged;
   logic [31:0] result;
   crc_ctl_type crc_ctl;
   logic [31:0] crc_next;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SEQUENCE_KEY: key_ff  <= csr_data;
            CSR_UNMUNGE_MODE: mode_ff <= csr_data[0];
         endcase
      end
   end

   // pipeline flow, bubbles collapse
   assign load_o    = !vo_ff || !rsp_stall;
   assign load3     = !v3_ff || load_o;
   assign load2     = !v2_ff || load3;
   assign load1     = !v1_ff || load2;
   assign req_stall = !load1;
   assign accept    = req_valid && load1;

   // munge lanes
   assign count_clamp = req_data.in_byte_count[2] ? FULL_COUNT : req_data.in_byte_count;
   assign full        = (count_clamp == FULL_COUNT);

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      mbmc_lane u_lane (
         .lane_idx (2'(g)),
         .unmunge  (mode_ff),
         .group    (group_ff[3:0]),
         .src_byte (req_data.in_word[8*(LANES-1-g) +: 8]),
         .src_key  (key_ff[8*(LANES-1-g) +: 8]),
         .dst_key  (key_ff[8*g +: 8]),
         .out_byte (munged[8*g +: 8])
      );
   end

   assign result = full ? munged : req_data.in_word;

   always_comb begin
      s1_in.result = result;
      s1_in.plain  = (mode_ff && full) ? result : req_data.in_word;
      s1_in.count  = count_clamp;
      s1_in.last   = req_data.in_last;
      s1_in.key    = key_ff;
   end

   assign group_in = accept ? (req_data.in_last ? 6'd0 : group_ff + 6'd1) : group_ff;

   // crc merge
   assign crc_ctl.take  = v1_ff && load2;
   assign crc_ctl.last  = s1_ff.last;
   assign crc_ctl.count = s1_ff.count;

   mbmc_crc u_crc (
      .clock      (clock),
      .reset      (reset),
      .ctl        (crc_ctl),
      .plain_word (s1_ff.plain),
      .crc_next   (crc_next)
   );

   always_comb begin
      s2_in.result = s1_ff.result;
      s2_in.count  = s1_ff.count;
      s2_in.last   = s1_ff.last;
      s2_in.crc    = crc_next;
      s2_in.seed   = seed_of(s1_ff.key);
   end

   always_comb begin
      s3_in.result = s2_ff.result;
      s3_in.count  = s2_ff.count;
      s3_in.last   = s2_ff.last;
      s3_in.crc    = s2_ff.crc;
      s3_in.tail   = tail_bytes(s2_ff.seed);
   end

   always_comb begin
      logic [31:0] c;
      c = s3_ff.crc;
      for (int i = 0; i < 4; i++) begin
         c = crc_byte(c, s3_ff.tail[8*i +: 8]);
      end
      rsp_in.out_word       = s3_ff.result;
      rsp_in.out_byte_count = s3_ff.count;
      rsp_in.out_last       = s3_ff.last;
      rsp_in.checksum_byte  = s3_ff.last ? ~c[7:0] : 8'd0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         vo_ff    <= 1'b0;
      end else begin
         group_ff <= group_in;
         if (load1)  v1_ff <= req_valid;
         if (load2)  v2_ff <= v1_ff;
         if (load3)  v3_ff <= v2_ff;
         if (load_o) vo_ff <= v3_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept)          s1_ff  <= s1_in;
      if (load2 && v1_ff)  s2_ff  <= s2_in;
      if (load3 && v2_ff)  s3_ff  <= s3_in;
      if (load_o && v3_ff) rsp_ff <= rsp_in;
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams packet bodies through move_body_munge_and_checksum under a range of
// keys and both modes. A scoreboard predicts every result word and checksum
// byte. Sender gaps and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module testbench;
   import mbmc_pkg::*;

   localparam int  IDLE_LIMIT     = 4000;
   localparam int  PHASES         = 9;
   localparam int  ITEMS_PER_PHASE = 165;
   localparam logic [127:0] MIX_ROM = {
      8'hC7, 8'h8E, 8'hDF, 8'h4A, 8'h0D, 8'h61, 8'hED, 8'hCA,
      8'hB5, 8'hA0, 8'h9B, 8'h1B, 8'hF1, 8'h05, 8'h64, 8'h7A
   };
   localparam logic [31:0] LANE_PATTERN = 32'h1B0A0300;

   class body_scoreboard;
      logic [31:0] key;
      logic        unmunge;
      logic [31:0] crc;
      logic [5:0]  group;
      logic [7:0]  plain_count;
      rsp_payload_type expected_q[$];
      int errors;

      function new();
         key         = '0;
         unmunge     = 1'b0;
         crc         = 32'hFFFFFFFF;
         group       = '0;
         plain_count = '0;
         errors      = 0;
      endfunction

      function logic [31:0] crc_entry(input logic [7:0] idx);
         logic [31:0] v;
         v = {24'd0, idx};
         repeat (8) begin
            if (v[0]) v = (v >> 1) ^ 32'hEDB88320;
            else v = v >> 1;
         end
         return v;
      endfunction

      function logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
         return crc_entry(c[7:0] ^ b) ^ (c >> 8);
      endfunction

      function logic [31:0] mix_lanes(input logic [31:0] v);
         logic [31:0] r;
         logic [3:0]  slot;
         logic [7:0]  mix;
         for (int lane = 0; lane < 4; lane++) begin
            slot = group[3:0] + 4'(lane);
            mix  = 8'hA5 | LANE_PATTERN[8*lane +: 8] | MIX_ROM[8*slot +: 8];
            r[8*lane +: 8] = v[8*lane +: 8] ^ mix;
         end
         return r;
      endfunction

      function void absorb(input logic [31:0] w, input logic [2:0] n);
         for (int i = 0; i < n; i++) begin
            if (plain_count < 8'd60) crc = crc_feed(crc, w[8*i +: 8]);
            if (plain_count != 8'hFF) plain_count = plain_count + 8'd1;
         end
      endfunction

      function void write_reg(input csr_index_type idx, input logic [31:0] data);
         case (idx)
            CSR_SEQUENCE_KEY: key = data;
            CSR_UNMUNGE_MODE: unmunge = data[0];
            default: ;
         endcase
      endfunction

      function void note_input(input req_payload_type p);
         rsp_payload_type r;
         logic [2:0]  n;
         logic [31:0] v;
         logic [31:0] c;
         logic [31:0] ent;
         logic [9:0]  seed;
         logic [9:0]  off;
         n = (p.in_byte_count > 3'd4) ? 3'd4 : p.in_byte_count;
         r.out_word = p.in_word;
         r.checksum_byte = '0;
         if (n == 3'd4) begin
            v = p.in_word ^ key;
            if (!unmunge) begin
               absorb(p.in_word, 3'd4);
               v = {v[7:0], v[15:8], v[23:16], v[31:24]};
               v = mix_lanes(v);
            end else begin
               v = mix_lanes(v);
               v = {v[7:0], v[15:8], v[23:16], v[31:24]};
            end
            r.out_word = v ^ ~key;
            if (unmunge) absorb(r.out_word, 3'd4);
         end else begin
            absorb(p.in_word, n);
         end
         group = group + 6'd1;
         if (p.in_last) begin
            seed = 10'(key % 32'd1020);
            c = crc;
            for (int i = 0; i < 4; i++) begin
               off = seed + 10'(i);
               ent = crc_entry(off[9:2]);
               c = crc_feed(c, ent[8*off[1:0] +: 8]);
            end
            r.checksum_byte = ~c[7:0];
            crc         = 32'hFFFFFFFF;
            group       = '0;
            plain_count = '0;
         end
         r.out_byte_count = n;
         r.out_last = p.in_last;
         expected_q.push_back(r);
      endfunction

      function void check_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result item word %h", got.out_word);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.out_word !== want.out_word) begin
            $error("out_word expected %h actual %h", want.out_word, got.out_word);
            errors++;
         end
         if (got.out_byte_count !== want.out_byte_count) begin
            $error("out_byte_count expected %0d actual %0d",
                   want.out_byte_count, got.out_byte_count);
            errors++;
         end
         if (got.out_last !== want.out_last) begin
            $error("out_last expected %b actual %b", want.out_last, got.out_last);
            errors++;
         end
         if (got.checksum_byte !== want.checksum_byte) begin
            $error("checksum_byte expected %h actual %h",
                   want.checksum_byte, got.checksum_byte);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   csr_index_type   csr_index;
   logic [31:0]     csr_data;

   body_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int items_sent;
   int idle_cycles;

   move_body_munge_and_checksum uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall) sb.note_input(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((csr_valid && csr_ready) || (req_valid && !req_stall)
             || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_item(input logic [31:0] w, input logic [2:0] n, input logic last);
      req_payload_type p;
      p.in_word       = w;
      p.in_byte_count = n;
      p.in_last       = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // leaves csr_valid high so writes can follow back to back
   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // waits until all expected results are in, then idles before returning
   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(15))
         0: return 32'h00000000;
         1: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_body(input int words);
      for (int i = 0; i < words; i++) begin
         if (i == words - 1) send_item(rand_word(), 3'($urandom_range(1, 4)), 1'b1);
         else send_item(rand_word(), 3'd4, 1'b0);
      end
   endtask

   initial begin
      logic [31:0] phase_key;
      logic        phase_mode;
      sb = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_SEQUENCE_KEY;
      csr_data       <= '0;
      send_idle_pct  = 18;
      recv_stall_pct = 71;
      items_sent     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items under the reset configuration
      send_item(32'h00000000, 3'd4, 1'b0);
      send_item(32'hFFFFFFFF, 3'd4, 1'b0);
      send_item(32'h01234567, 3'd4, 1'b1);
      send_item(32'hDEADBEEF, 3'd0, 1'b1);
      send_item(32'h89ABCDEF, 3'd5, 1'b0);
      send_item(32'h13579BDF, 3'd6, 1'b0);
      send_item(32'h2468ACE0, 3'd7, 1'b1);
      send_item(32'hA5A5A5A5, 3'd2, 1'b0);
      send_item(32'h5A5A5A5A, 3'd4, 1'b0);
      send_item(32'hCAFEF00D, 3'd3, 1'b1);
      send_item(32'hFFFFFFFF, 3'd1, 1'b1);
      send_item(32'h00000000, 3'd4, 1'b1);
      send_item(32'h80000001, 3'd0, 1'b0);
      send_item(32'h7FFFFFFE, 3'd4, 1'b1);
      // long body: group wraps and the byte count saturates
      send_body(70);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin phase_key = 32'hFFFFFFFF; phase_mode = 1'b0; end
            1: begin phase_key = 32'h00000000; phase_mode = 1'b1; end
            2: begin phase_key = 32'd1019;     phase_mode = 1'b1; end
            3: begin phase_key = 32'd1020;     phase_mode = 1'b0; end
            4: begin phase_key = 32'hFFFFFFFF; phase_mode = 1'b1; end
            default: begin
               phase_key  = $urandom;
               phase_mode = 1'($urandom_range(1));
            end
         endcase
         if (phase < 3) begin
            send_idle_pct = 18; recv_stall_pct = 71;
         end else if (phase < 6) begin
            send_idle_pct = 71; recv_stall_pct = 18;
         end else begin
            send_idle_pct = 0; recv_stall_pct = 0;
         end
         if ($urandom_range(1)) begin
            write_csr(CSR_SEQUENCE_KEY, phase_key);
            write_csr(CSR_UNMUNGE_MODE, {31'($urandom), phase_mode});
         end else begin
            write_csr(CSR_UNMUNGE_MODE, {31'($urandom), phase_mode});
            write_csr(CSR_SEQUENCE_KEY, phase_key);
         end
         csr_valid <= 1'b0;

         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            case ($urandom_range(9))
               0: send_item(rand_word(), 3'($urandom_range(7)), 1'($urandom_range(1)));
               1: send_body($urandom_range(60, 80));
               default: send_body($urandom_range(1, 16));
            endcase
         end
         // odd phases leave a body open across the register writes
         if (phase % 2 == 1) begin
            send_item(rand_word(), 3'd4, 1'b0);
            send_item(rand_word(), 3'd4, 1'b0);
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
